// ----- rtl/skt_pkg.sv -----
// shared types and constants for the sorted key table
package skt_pkg;

  // fixed field widths
  localparam int KEY_W = 31;
  localparam int POS_W = 9;
  localparam int FH_W  = 16;

  // request operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } rsp_status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMPARE,
    S_DECIDE,
    S_SHIFT,
    S_FLUSH,
    S_WRITE,
    S_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic idle;
    logic load;
    logic rd_mid;
    logic cmp;
    logic search_end;
    logic latch;
    logic shift_init;
    logic shift_step;
    logic flush;
    logic write_new;
    logic post;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic range_empty;
    logic key_eq;
    logic hit;
    logic is_insert;
    logic full;
    logic no_shift;
    logic shift_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/skt_req_if.sv -----
// request channel: operation, key and handle with valid/ready
interface skt_req_if import skt_pkg::*; #(
  parameter int HANDLE_BITS = 16
) ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [KEY_W-1:0]       key;
  logic [HANDLE_BITS-1:0] handle;

  modport source (output valid, output operation, output key, output handle, input ready);
  modport sink   (input valid, input operation, input key, input handle, output ready);
endinterface

// ----- rtl/skt_rsp_if.sv -----
// response channel: status, position and found handle with valid/ready
interface skt_rsp_if import skt_pkg::*; ();
  logic              valid;
  logic              ready;
  rsp_status_t       status;
  logic [POS_W-1:0]  position;
  logic [FH_W-1:0]   found_handle;

  modport source (output valid, output status, output position, output found_handle,
                  input ready);
  modport sink   (input valid, input status, input position, input found_handle,
                  output ready);
endinterface

// ----- rtl/skt_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/skt_ctrl.sv -----
// controller state machine: search, shift and result sequencing
module skt_ctrl import skt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        state_next = sts.range_empty ? S_DECIDE : S_COMPARE;
      end
      S_COMPARE: begin
        state_next = sts.key_eq ? S_DECIDE : S_SEARCH;
      end
      S_DECIDE: begin
        if (!sts.is_insert || sts.hit || sts.full) begin
          state_next = S_RESULT;
        end else if (sts.no_shift) begin
          state_next = S_WRITE;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts.shift_last) state_next = S_FLUSH;
      end
      S_FLUSH: begin
        state_next = S_WRITE;
      end
      S_WRITE: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        cmd.load = req_valid;
      end
      S_SEARCH: begin
        cmd.rd_mid     = !sts.range_empty;
        cmd.search_end = sts.range_empty;
      end
      S_COMPARE: cmd.cmp = 1'b1;
      S_DECIDE: begin
        cmd.latch      = 1'b1;
        cmd.shift_init = 1'b1;
      end
      S_SHIFT:  cmd.shift_step = 1'b1;
      S_FLUSH:  cmd.flush = 1'b1;
      S_WRITE:  cmd.write_new = 1'b1;
      S_RESULT: cmd.post = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ----- rtl/skt_dp.sv -----
// datapath: search bounds, entry ram, shift pointers and response register
module skt_dp import skt_pkg::*; #(
  parameter int CAPACITY    = 256,
  parameter int HANDLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic                   operation,
  input  logic [KEY_W-1:0]       key,
  input  logic [HANDLE_BITS-1:0] handle,
  input  logic                   out_ready,
  output logic                   out_valid,
  output rsp_status_t            out_status,
  output logic [POS_W-1:0]       out_position,
  output logic [FH_W-1:0]        out_handle
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int EW = KEY_W + HANDLE_BITS;

  // captured request
  logic                   op_q;
  logic [KEY_W-1:0]       key_q;
  logic [HANDLE_BITS-1:0] handle_q;

  // search state
  logic [PW-1:0]          lo;
  logic [PW-1:0]          hi;
  logic [PW-1:0]          mid_q;
  logic [PW-1:0]          where;
  logic                   hit;
  logic [HANDLE_BITS-1:0] hit_handle;
  logic [PW-1:0]          count;

  // shift state
  logic [AW-1:0]          sh_idx;
  logic [AW-1:0]          wr_addr;
  logic                   wr_pend;

  // latched result
  rsp_status_t            res_status;
  logic [HANDLE_BITS-1:0] res_handle;

  // ram signals
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  logic [KEY_W-1:0]       rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;

  logic [PW-1:0]          mid;
  logic                   full;
  logic [HANDLE_BITS+FH_W-1:0] fh_ext;
  logic [PW+POS_W-1:0]         pos_ext;

  // entry store, key above handle
  skt_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key    = ram_rdata[EW-1 -: KEY_W];
  assign rd_handle = ram_rdata[HANDLE_BITS-1:0];

  // midpoint of the open search range
  assign mid  = lo + ((hi - lo) >> 1);
  assign full = (count == PW'(CAPACITY));

  // ram port selection: shifted entry or new pair
  always_comb begin
    ram_raddr = cmd.shift_step ? sh_idx : mid[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = ram_rdata;
    if ((cmd.shift_step && wr_pend) || cmd.flush) begin
      ram_we = 1'b1;
    end else if (cmd.write_new) begin
      ram_we    = 1'b1;
      ram_waddr = where[AW-1:0];
      ram_wdata = {key_q, handle_q};
    end
  end

  // status to controller
  always_comb begin
    sts.range_empty = (lo >= hi);
    sts.key_eq      = (key_q == rd_key);
    sts.hit         = hit;
    sts.is_insert   = (op_q == OP_INSERT);
    sts.full        = full;
    sts.no_shift    = (count == where);
    sts.shift_last  = (sh_idx == where[AW-1:0]);
    sts.out_free    = !out_valid || out_ready;
  end

  // request capture and binary search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q       <= operation;
      key_q      <= key;
      handle_q   <= handle;
      lo         <= '0;
      hi         <= count;
      hit        <= 1'b0;
      hit_handle <= '0;
    end
    if (cmd.rd_mid) begin
      mid_q <= mid;
    end
    if (cmd.search_end) begin
      where <= lo;
    end
    if (cmd.cmp) begin
      if (key_q == rd_key) begin
        hit        <= 1'b1;
        where      <= mid_q;
        hit_handle <= rd_handle;
      end else if (key_q < rd_key) begin
        hi <= mid_q;
      end else begin
        lo <= mid_q + PW'(1);
      end
    end
  end

  // shift pointers, walking down from the top entry
  always_ff @(posedge clk) begin
    if (cmd.shift_init) begin
      sh_idx  <= AW'(count - PW'(1));
      wr_pend <= 1'b0;
    end else if (cmd.shift_step) begin
      wr_pend <= 1'b1;
      wr_addr <= sh_idx + AW'(1);
      sh_idx  <= sh_idx - AW'(1);
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.write_new) begin
      count <= count + PW'(1);
    end
  end

  // result code, fixed before the table changes
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      res_handle <= hit ? hit_handle : '0;
      if (op_q == OP_LOOKUP) begin
        res_status <= hit ? ST_OK : ST_MISSING;
      end else if (hit) begin
        res_status <= ST_DUPLICATE;
      end else if (full) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_OK;
      end
    end
  end

  assign fh_ext  = {{FH_W{1'b0}}, res_handle};
  assign pos_ext = {{POS_W{1'b0}}, where};

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.post) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      out_status   <= res_status;
      out_position <= pos_ext[POS_W-1:0];
      out_handle   <= fh_ext[FH_W-1:0];
    end
  end

endmodule

// ----- rtl/sorted_key_table_top.sv -----
// top level of the sorted key table: controller, datapath and channels
// Sorted key table: holds up to CAPACITY key/handle pairs in ascending key order in one
// simple dual-port RAM and serves one request at a time. A request is taken when the
// block is idle, even while the previous response still waits on rsp. A lookup is
// accepted, then runs binary-search steps (RAM read, then compare), up to
// ceil(log2(CAPACITY+1)) steps, with one closing range check on a miss, then a decide
// and a result state. A successful insert then moves each entry above its position up
// (one RAM read and one write per cycle), flushes the last moved entry and writes the
// new pair, or writes the pair at once when nothing moves; the single RAM read port
// bounds both the search and the shift. The table needs no clearing after reset:
// only entries below the count are ever read.
module sorted_key_table_top import skt_pkg::*; #(
  parameter int CAPACITY    = 256,
  parameter int HANDLE_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  skt_req_if.sink  req,
  skt_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  assign req.ready = cmd.idle;

  // sequencing
  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // table storage and result
  skt_dp #(
    .CAPACITY    (CAPACITY),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (req.operation),
    .key          (req.key),
    .handle       (req.handle),
    .out_ready    (rsp.ready),
    .out_valid    (rsp.valid),
    .out_status   (rsp.status),
    .out_position (rsp.position),
    .out_handle   (rsp.found_handle)
  );

endmodule

// ----- rtl/skt_checker.sv -----
// port-level checks for the sorted key table and their binding
module skt_checker import skt_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input rsp_status_t      rsp_status,
  input logic [FH_W-1:0]  rsp_found_handle
);

  // a response waits until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped before it was taken");

  // one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // reset empties the response register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // misses and full-table rejects carry no handle
  a_no_handle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_MISSING || rsp_status == ST_FULL)
      |-> rsp_found_handle == '0)
    else $error("handle reported on a miss or full table");

endmodule

bind sorted_key_table_top skt_checker u_skt_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_found_handle (rsp.found_handle)
);

// ----- verif/tb_sorted_key_table_top.sv -----
`timescale 1ns / 1ps
// testbench for the sorted key table: lookups and inserts checked against a behavioral table
module tb_sorted_key_table_top;
  import skt_pkg::*;

  localparam int CAPACITY    = 256;
  localparam int HANDLE_BITS = 16;
  localparam int MAX_REPORTS = 10;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct {
    logic                   operation;
    logic [KEY_W-1:0]       key;
    logic [HANDLE_BITS-1:0] handle;
    int                     gap;
    bit                     drain;
  } table_req_t;

  typedef struct {
    rsp_status_t      status;
    logic [POS_W-1:0] position;
    logic [FH_W-1:0]  found_handle;
  } table_rsp_t;

  logic clk;
  logic rst;

  skt_req_if #(.HANDLE_BITS(HANDLE_BITS)) req_ch ();
  skt_rsp_if rsp_ch ();

  sorted_key_table_top #(
    .CAPACITY   (CAPACITY),
    .HANDLE_BITS(HANDLE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  table_req_t             pending_q[$];
  table_rsp_t             expected_rsp_q[$];
  logic [KEY_W-1:0]       gen_keys[$];
  logic [KEY_W-1:0]       shadow_keys[CAPACITY];
  logic [HANDLE_BITS-1:0] shadow_handles[CAPACITY];
  int                     shadow_count;
  int                     err_count;
  int                     req_count;
  int                     rsp_count;
  table_req_t             cur_req;
  table_rsp_t             exp_rsp;
  table_rsp_t             want;
  int                     gap_left;
  int                     stall_left;
  int                     quiet_left;
  bit                     hold_done;
  int                     ready_roll;

  // clock and known input levels from time zero
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_LOOKUP;
    req_ch.key       = '0;
    req_ch.handle    = '0;
    rsp_ch.ready     = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("[sorted_key_table_top] ERROR");
    $finish;
  end

  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // binary search, then lookup, duplicate, full table or shifting insert
  task automatic predict_table_op(input table_req_t r, output table_rsp_t res);
    int lo;
    int hi;
    int mid;
    int pos;
    bit hit;
    lo  = 0;
    hi  = shadow_count;
    pos = 0;
    hit = 1'b0;
    while (lo < hi && !hit) begin
      mid = lo + (hi - lo) / 2;
      if (r.key < shadow_keys[mid]) hi = mid;
      else if (r.key > shadow_keys[mid]) lo = mid + 1;
      else begin
        hit = 1'b1;
        pos = mid;
      end
    end
    if (!hit) pos = lo;
    res.position     = pos[POS_W-1:0];
    res.found_handle = '0;
    if (hit) begin
      res.status       = (r.operation == OP_INSERT) ? ST_DUPLICATE : ST_OK;
      res.found_handle = shadow_handles[pos];
    end else if (r.operation == OP_LOOKUP) begin
      res.status = ST_MISSING;
    end else if (shadow_count >= CAPACITY) begin
      res.status = ST_FULL;
    end else begin
      for (int i = shadow_count; i > pos; i--) begin
        shadow_keys[i]    = shadow_keys[i-1];
        shadow_handles[i] = shadow_handles[i-1];
      end
      shadow_keys[pos]    = r.key;
      shadow_handles[pos] = r.handle;
      shadow_count++;
      res.status = ST_OK;
    end
  endtask

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 300);
  endfunction

  // keys biased toward stored ones and their neighbors so hits and duplicates are common
  function automatic logic [KEY_W-1:0] pick_key(input logic op);
    int               r;
    logic [KEY_W-1:0] k;
    r = $urandom_range(0, 99);
    if (gen_keys.size() > 0 && r < 35) begin
      k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
    end else if (gen_keys.size() > 0 && r < 45) begin
      k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
      k = (k == '0 || $urandom_range(0, 1)) ? k + 1'b1 : k - 1'b1;
    end else if (r < 50) begin
      k = (op == OP_LOOKUP || gen_keys.size() >= CAPACITY) && $urandom_range(0, 1) ?
          KEY_MAX : '0;
    end else begin
      k = KEY_W'($urandom());
    end
    // keep the top key out of the table so a miss past the full table reports position 256
    if (op == OP_INSERT && k == KEY_MAX && gen_keys.size() < CAPACITY) k = KEY_MAX - 2'd2;
    return k;
  endfunction

  // queue one request and track which keys the table will hold
  task automatic add_req(input logic op, input logic [KEY_W-1:0] key,
                         input logic [HANDLE_BITS-1:0] hdl, input int gap, input bit drain);
    table_req_t r;
    bit         known;
    known = 1'b0;
    foreach (gen_keys[i]) if (gen_keys[i] == key) known = 1'b1;
    if (op == OP_INSERT && !known && gen_keys.size() < CAPACITY) gen_keys.push_back(key);
    r.operation = op;
    r.key       = key;
    r.handle    = hdl;
    r.gap       = gap;
    r.drain     = drain;
    pending_q.push_back(r);
  endtask

  // request driver; predicts the response of each accepted request
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_table_op(cur_req, exp_rsp);
        expected_rsp_q.push_back(exp_rsp);
        req_count++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0 && (!pending_q[0].drain || rsp_count == req_count))
        begin
          cur_req = pending_q.pop_front();
          gap_left = cur_req.gap;
          req_ch.valid     <= 1'b1;
          req_ch.operation <= cur_req.operation;
          req_ch.key       <= cur_req.key;
          req_ch.handle    <= cur_req.handle;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response checker and receiver pacing
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
      quiet_left = 0;
      hold_done  = 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_count++;
        if (expected_rsp_q.size() == 0) begin
          note_failure($sformatf("unexpected response: status %0d position %0d handle %h",
                                 rsp_ch.status, rsp_ch.position, rsp_ch.found_handle));
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.position !== want.position ||
              rsp_ch.found_handle !== want.found_handle)
            note_failure($sformatf(
              "response %0d: expected %s pos %0d handle %h, got status %0d pos %0d handle %h",
              rsp_count, want.status.name(), want.position, want.found_handle,
              rsp_ch.status, rsp_ch.position, rsp_ch.found_handle));
        end
      end
      // one long hold-off so the block backs up, otherwise random stalls and quiet stretches
      if (!hold_done && req_count >= 1000) begin
        hold_done  = 1'b1;
        stall_left = 1500;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        rsp_ch.ready <= 1'b1;
      end else begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 2) quiet_left = $urandom_range(100, 400);
        else if (ready_roll < 20) stall_left = pick_gap();
        rsp_ch.ready <= (ready_roll >= 2 && ready_roll < 20) ? 1'b0 : 1'b1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic op;
    // empty table misses at both key extremes
    add_req(OP_LOOKUP, '0, '1, pick_gap(), 1'b0);
    add_req(OP_LOOKUP, KEY_MAX, '0, pick_gap(), 1'b0);
    // inserts at the middle, bottom and near the top, handle extremes
    add_req(OP_INSERT, 31'h4000_0000, 16'hFFFF, pick_gap(), 1'b0);
    add_req(OP_INSERT, '0, 16'h0000, pick_gap(), 1'b0);
    add_req(OP_INSERT, 31'h7FFF_FFFE, 16'hA5A5, pick_gap(), 1'b0);
    // duplicate insert keeps the old handle
    add_req(OP_INSERT, 31'h4000_0000, 16'h1234, pick_gap(), 1'b0);
    // hits and misses next to stored keys
    add_req(OP_LOOKUP, '0, 16'h1111, pick_gap(), 1'b0);
    add_req(OP_LOOKUP, 31'h7FFF_FFFE, '0, pick_gap(), 1'b0);
    add_req(OP_LOOKUP, 31'h4000_0000, '0, pick_gap(), 1'b0);
    add_req(OP_LOOKUP, 31'h3FFF_FFFF, '0, pick_gap(), 1'b0);
    add_req(OP_LOOKUP, 31'h4000_0001, '0, pick_gap(), 1'b0);
    add_req(OP_LOOKUP, KEY_MAX, '1, pick_gap(), 1'b0);
    // alternating bit patterns, inserts that shift entries up
    add_req(OP_INSERT, 31'h2AAA_AAAA, 16'h5555, pick_gap(), 1'b0);
    add_req(OP_INSERT, 31'h5555_5555, 16'hAAAA, pick_gap(), 1'b0);
    add_req(OP_LOOKUP, 31'h2AAA_AAAA, 16'hFFFF, pick_gap(), 1'b0);
    add_req(OP_INSERT, '0, 16'hFFFF, pick_gap(), 1'b0);
    add_req(OP_INSERT, 31'h7FFF_FFFD, 16'h0001, pick_gap(), 1'b0);
    add_req(OP_LOOKUP, 31'h5555_5555, '0, pick_gap(), 1'b0);

    // random mix; the table fills partway through, after which full rejects appear
    for (int n = 0; n < 1832; n++) begin
      op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_LOOKUP;
      add_req(op, pick_key(op), HANDLE_BITS'($urandom()),
              (n % 400 < 60) ? 0 : pick_gap(), n == 400 || n == 1300);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || req_ch.valid || expected_rsp_q.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    if (err_count == 0 && expected_rsp_q.size() == 0) begin
      $display("[sorted_key_table_top] OK");
    end else begin
      $display("[sorted_key_table_top] ERROR");
    end
    $finish;
  end

endmodule
